// ----- rtl/core/kprt_pkg.sv -----
// ----------------------------------------------------------------------------
// kprt_pkg
// Shared constants, types and helpers of the keypad press repeat tracker.
// ----------------------------------------------------------------------------
package kprt_pkg;

    localparam int NUM_KEYS       = 16;
    localparam int KEY_IDX_W      = 4;
    localparam int TICK_W         = 32;
    localparam int DELAY_W        = 8;
    localparam int CMD_W          = 2;
    localparam int CFG_IDX_W      = 8;
    localparam int IN_TDATA_W     = 56;
    localparam int OUT_TDATA_W    = 8;

    localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 8'd20;
    localparam logic [DELAY_W-1:0] INTERVAL_RST    = 8'd5;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HELD   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 8'd1;

    typedef logic [NUM_KEYS-1:0] t_keys;

    function automatic logic [KEY_IDX_W-1:0] lowest_index(input t_keys v);
        logic [KEY_IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = KEY_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/core/keypad_press_repeat_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// keypad_press_repeat_tracker_unit
// 16-key keypad tracker with press detection, locking and auto-repeat.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream. The command sits in s_tuser; tdata
// carries the held-key vector, the tick, the key index and the player. Every
// request gives exactly one response on the master stream: the pressed flag,
// the key code and the held bit.
// A request is captured in an input register; the command logic then reads and
// updates the key state and loads the response register once that is free.
// o_m_tvalid rises once the request has passed both the input register and
// the response register. One request is taken in every cycle while the
// receiver keeps i_m_tready high.
// When the receiver stalls, the response holds and the input register fills;
// o_s_tready then drops until the response is taken.
// The configuration channel writes the first repeat delay (index 0) and the
// repeat interval (index 1); other indexes are ignored. It is always ready;
// the user writes it only while the block is idle; the block does not enforce it.
// Reset clears both streams, all key state, and loads the delays 20 and 5.
// ----------------------------------------------------------------------------
module keypad_press_repeat_tracker_unit
    import kprt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // keys_held[15:0], tick[47:16], key_index[51:48], player[52], zero[55:53]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]       i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // pressed[0], key_code[4:1], held[5], zero[7:6]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DELAY_W-1:0]     i_cfg_data
);

    logic                 r_in_valid;
    logic [CMD_W-1:0]     r_cmd;
    t_keys                r_keys_in;
    logic [TICK_W-1:0]    r_tick;
    logic [KEY_IDX_W-1:0] r_key_idx;
    logic                 r_player;

    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [DELAY_W-1:0]   r_first_delay;
    logic [DELAY_W-1:0]   r_interval;

    t_keys                r_prev, n_prev;
    t_keys                r_curr, n_curr;
    t_keys                r_lock, n_lock;
    t_keys                r_rep, n_rep;
    logic [TICK_W-1:0]    r_last_tick, n_last_tick;
    logic [DELAY_W-1:0]   r_delay, n_delay;

    logic                 advance;
    logic                 in_accept;
    logic [TICK_W-1:0]    due;
    logic                 rearm;
    t_keys                prev_m;
    t_keys                fresh;
    t_keys                diff;
    t_keys                sel;
    t_keys                low;
    logic [KEY_IDX_W:0]   pos;
    t_keys                avail;
    logic                 pressed;
    logic [KEY_IDX_W-1:0] key_code;
    logic                 held;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        due    = r_last_tick + TICK_W'(r_delay);
        rearm  = r_tick >= due;
        prev_m = rearm ? (r_prev & ~r_rep) : r_prev;
        fresh  = r_curr & ~prev_m;
        diff   = fresh & ~r_rep;
        sel    = (|diff) ? diff : r_rep;
        low    = sel & (~sel + t_keys'(1));
        pos    = {1'b0, r_key_idx} + {2'b00, r_player, 2'b00};
        avail  = r_curr & ~r_lock;

        n_prev      = r_prev;
        n_curr      = r_curr;
        n_lock      = r_lock;
        n_rep       = r_rep;
        n_last_tick = r_last_tick;
        n_delay     = r_delay;
        pressed     = 1'b0;
        key_code    = '0;
        held        = 1'b0;

        case (r_cmd)
            CMD_SAMPLE: begin
                n_prev = r_curr;
                n_curr = r_keys_in;
                n_lock = r_lock & ~(r_curr ^ r_keys_in);
                n_rep  = r_rep & n_lock;
            end
            CMD_PRESS: begin
                n_prev = prev_m;
                if (|fresh) begin
                    n_lock      = r_lock | sel;
                    n_last_tick = r_tick;
                    n_delay     = (sel != r_rep) ? r_first_delay : r_interval;
                    n_rep       = low;
                    pressed     = 1'b1;
                    key_code    = lowest_index(low);
                end
            end
            CMD_HELD: begin
                if (pos < (KEY_IDX_W + 1)'(NUM_KEYS)) begin
                    held = avail[pos[KEY_IDX_W-1:0]];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_first_delay <= FIRST_DELAY_RST;
            r_interval    <= INTERVAL_RST;
            r_prev        <= '0;
            r_curr        <= '0;
            r_lock        <= '0;
            r_rep         <= '0;
            r_last_tick   <= '0;
            r_delay       <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_prev      <= n_prev;
                r_curr      <= n_curr;
                r_lock      <= n_lock;
                r_rep       <= n_rep;
                r_last_tick <= n_last_tick;
                r_delay     <= n_delay;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_FIRST_DELAY) begin
                    r_first_delay <= i_cfg_data;
                end else if (i_cfg_index == REG_INTERVAL) begin
                    r_interval <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd     <= i_s_tuser;
            r_keys_in <= i_s_tdata[NUM_KEYS-1:0];
            r_tick    <= i_s_tdata[16 +: TICK_W];
            r_key_idx <= i_s_tdata[48 +: KEY_IDX_W];
            r_player  <= i_s_tdata[52];
        end
        if (advance) begin
            r_out_data <= {2'b00, held, key_code, pressed};
        end
    end

endmodule

// ----- rtl/core/kprt_checker.sv -----
// ----------------------------------------------------------------------------
// kprt_checker
// Port-level checks of the keypad press repeat tracker, bound to the top level.
// ----------------------------------------------------------------------------
module kprt_checker
    import kprt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // A stalled response stays valid and unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled response changed");

    // Reset empties the response stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Response valid after reset");

    // The key code is zero when no press is reported.
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[4:1] == 4'd0)
        else $error("Key code without press");

    // A press and a held answer never come from the same request, and the top bits are zero.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[5]) && o_m_tdata[7:6] == 2'b00)
        else $error("Mixed response fields");

endmodule

bind keypad_press_repeat_tracker_unit kprt_checker u_kprt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
